@@ design/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ design/acl_pkg.sv @@
// Shared types, constants and helper functions for the ACL classifier
package acl_pkg;
	localparam int WHITE_DEPTH = 64;
	localparam int BLACK_DEPTH = 16;
	localparam int PORT_PAT_LEN = 6;
	localparam int WIDX_W = $clog2(WHITE_DEPTH);
	localparam int BIDX_W = $clog2(BLACK_DEPTH);
	localparam int WCNT_W = $clog2(WHITE_DEPTH + 1);
	localparam int BCNT_W = $clog2(BLACK_DEPTH + 1);
	localparam int QDEPTH = 2;

	localparam logic [3:0] CH_ANY1 = 4'd10;
	localparam logic [3:0] CH_STAR = 4'd11;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam logic [1:0] LIST_WHITE = 2'd0;
	localparam logic [1:0] LIST_BLACK = 2'd1;

	localparam logic [1:0] FAM_IPV4 = 2'd0;
	localparam logic [1:0] FAM_IPV6 = 2'd1;
	localparam logic [1:0] FAM_UNSPEC = 2'd2;
	localparam logic [1:0] FAM_OTHER = 2'd3;

	localparam logic [1:0] DIR_ANY = 2'd0;
	localparam logic [1:0] DIR_IN = 2'd1;
	localparam logic [1:0] DIR_OUT = 2'd2;

	localparam logic [2:0] CAUSE_WHITE_HIT = 3'd0;
	localparam logic [2:0] CAUSE_BLACK_HIT = 3'd1;
	localparam logic [2:0] CAUSE_NOT_WHITE = 3'd2;
	localparam logic [2:0] CAUSE_IPV6 = 3'd3;
	localparam logic [2:0] CAUSE_UNSPEC = 3'd4;
	localparam logic [2:0] CAUSE_OTHER = 3'd5;
	localparam logic [2:0] CAUSE_ADDED = 3'd6;
	localparam logic [2:0] CAUSE_IGNORED = 3'd7;

	// check transaction handed from front to back
	typedef struct packed {
		logic [31:0] ip;
		logic [19:0] digits;   // five digits, first in top nibble
		logic [2:0] ndig;
		logic inbound;
	} chk_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [3:0] wild;
		logic [23:0] chars;
		logic [2:0] len;
		logic [1:0] dir;
	} rule_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BLACK,
		ST_WHITE,
		ST_DONE
	} scan_st_t;

	function automatic logic ip_match(rule_t r, logic [31:0] ip);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 4; i++)
			if (!r.wild[3-i] && (r.ip[31-8*i -: 8] != ip[31-8*i -: 8]))
				ok = 1'b0;
		return ok;
	endfunction

	// glob over at most five digits: dp[i][j] = pattern[0..i) matches digits[0..j)
	function automatic logic glob_match(logic [23:0] chars, logic [2:0] len,
			logic [19:0] dg, logic [2:0] nd);
		logic [5:0] dp [0:6];
		logic [3:0] c;
		logic [3:0] d;
		for (int i = 0; i <= 6; i++)
			dp[i] = '0;
		dp[0][0] = 1'b1;
		for (int i = 1; i <= 6; i++) begin
			c = chars[23-4*(i-1) -: 4];
			for (int j = 0; j <= 5; j++) begin
				d = (j > 0) ? dg[19-4*(j-1) -: 4] : 4'd0;
				if (c == CH_STAR)
					dp[i][j] = dp[i-1][j] | ((j > 0) ? dp[i][j-1] : 1'b0);
				else if (j > 0)
					dp[i][j] = dp[i-1][j-1] & ((c == CH_ANY1) || (c == d && d < 4'd10));
			end
		end
		return (len != 3'd0) && dp[len][nd];
	endfunction
endpackage

@@ design/connection_acl_classifier.sv @@
// An add or a non-IPv4 check is answered on done in the cycle after start is accepted.
// An IPv4 check splits the port into decimal digits, is queued and popped, then scans
// the stored rules (blacklist, then whitelist) until a hit or the end of both lists.
// Throughput: one transaction at a time; busy stays high until a check is answered.
// Reset (arst_n low, asynchronous) empties both tables and the queue.
// Results are a one-cycle strobe on done; the receiver cannot stall.
module connection_acl_classifier (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cmd,
	input logic [1:0] rule_list,
	input logic [31:0] rule_ip,
	input logic [3:0] rule_octet_wild,
	input logic [23:0] rule_port_chars,
	input logic [2:0] rule_port_len,
	input logic [1:0] rule_dir,
	input logic [1:0] family,
	input logic [31:0] peer_ip,
	input logic [15:0] peer_port,
	input logic inbound,
	output logic done,
	output logic allowed,
	output logic [2:0] cause,
	output logic [5:0] hit_index
);
	import acl_pkg::*;

	logic in_ready, wr_white, wr_black, q_push, q_full, q_pop, q_nempty;
	logic [WIDX_W-1:0] wr_widx;
	logic [BIDX_W-1:0] wr_bidx;
	rule_t wr_rule;
	logic [WCNT_W-1:0] white_cnt;
	logic [BCNT_W-1:0] black_cnt;
	chk_t q_wdata, q_rdata;
	logic fr_valid, fr_allowed, sc_valid, sc_allowed, sc_busy;
	logic [2:0] fr_cause, sc_cause;
	logic [5:0] sc_hit;
	logic dv_q, al_q;
	logic [2:0] ca_q;
	logic [5:0] hi_q;

	// a scan result and a front result in the same cycle would collide; hold front
	// while the engine may finish (engine busy or queue nonempty)
	assign busy = !in_ready || sc_busy || q_nempty;

	acl_front u_front (
		.clk, .arst_n, .in_valid(start && !busy), .in_ready,
		.cmd, .rule_list, .rule_ip, .rule_octet_wild, .rule_port_chars,
		.rule_port_len, .rule_dir, .family, .peer_ip, .peer_port, .inbound,
		.wr_white, .wr_black, .wr_widx, .wr_bidx, .wr_rule, .white_cnt, .black_cnt,
		.q_push, .q_full, .q_data(q_wdata), .fr_valid, .fr_allowed, .fr_cause
	);

	acl_queue u_queue (
		.clk, .arst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .nempty(q_nempty), .rdata(q_rdata)
	);

	acl_scan u_scan (
		.clk, .arst_n, .wr_white, .wr_black, .wr_widx, .wr_bidx, .wr_rule,
		.white_cnt, .black_cnt, .q_nempty, .q_data(q_rdata), .q_pop,
		.sc_valid, .sc_allowed, .sc_cause, .sc_hit, .busy(sc_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_q <= 1'b0;
		else
			dv_q <= (fr_valid && !busy) || sc_valid;
	end

	always_ff @(posedge clk) begin
		if (sc_valid) begin
			al_q <= sc_allowed;
			ca_q <= sc_cause;
			hi_q <= sc_hit;
		end else begin
			al_q <= fr_allowed;
			ca_q <= fr_cause;
			hi_q <= '0;
		end
	end

	assign done = dv_q;
	assign allowed = al_q;
	assign cause = ca_q;
	assign hit_index = hi_q;
endmodule

@@ design/acl_front.sv @@
// Front end: command decode, family decisions, table appends, port digit split
module acl_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic [1:0] rule_list,
	input logic [31:0] rule_ip,
	input logic [3:0] rule_octet_wild,
	input logic [23:0] rule_port_chars,
	input logic [2:0] rule_port_len,
	input logic [1:0] rule_dir,
	input logic [1:0] family,
	input logic [31:0] peer_ip,
	input logic [15:0] peer_port,
	input logic inbound,
	output logic wr_white,
	output logic wr_black,
	output logic [acl_pkg::WIDX_W-1:0] wr_widx,
	output logic [acl_pkg::BIDX_W-1:0] wr_bidx,
	output acl_pkg::rule_t wr_rule,
	output logic [acl_pkg::WCNT_W-1:0] white_cnt,
	output logic [acl_pkg::BCNT_W-1:0] black_cnt,
	output logic q_push,
	input logic q_full,
	output acl_pkg::chk_t q_data,
	output logic fr_valid,
	output logic fr_allowed,
	output logic [2:0] fr_cause
);
	import acl_pkg::*;

	logic [WCNT_W-1:0] wcnt_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic cv_q;
	logic [15:0] port_q;
	logic [19:0] dig_q;
	logic [2:0] nd_q;
	logic [31:0] ip_q;
	logic inb_q;
	logic [15:0] quo;
	logic [3:0] rem;

	assign in_ready = !cv_q && !q_full;
	assign white_cnt = wcnt_q;
	assign black_cnt = bcnt_q;

	// divide by ten: q = (x*52429)>>19 is exact for 16-bit x
	always_comb begin
		quo = 16'((33'(port_q) * 33'd52429) >> 19);
		rem = 4'(port_q - 16'(quo * 16'd10));
	end

	logic [2:0] plen;
	always_comb begin
		plen = (rule_port_len > 3'(PORT_PAT_LEN)) ? 3'(PORT_PAT_LEN) : rule_port_len;
		wr_rule = '{ip: rule_ip, wild: rule_octet_wild, chars: rule_port_chars,
			len: plen, dir: rule_dir};
		wr_widx = wcnt_q[WIDX_W-1:0];
		wr_bidx = bcnt_q[BIDX_W-1:0];
		wr_white = in_valid && in_ready && cmd == CMD_ADD && rule_list == LIST_WHITE
			&& wcnt_q < WCNT_W'(WHITE_DEPTH);
		wr_black = in_valid && in_ready && cmd == CMD_ADD && rule_list == LIST_BLACK
			&& bcnt_q < BCNT_W'(BLACK_DEPTH);
		fr_valid = in_valid && in_ready && !(cmd == CMD_CHECK && family == FAM_IPV4);
		fr_allowed = 1'b0;
		fr_cause = CAUSE_IGNORED;
		if (cmd == CMD_ADD) begin
			if (wr_white || wr_black) begin
				fr_allowed = 1'b1;
				fr_cause = CAUSE_ADDED;
			end
		end else begin
			unique case (family)
				FAM_IPV6: fr_cause = CAUSE_IPV6;
				FAM_UNSPEC: begin
					fr_allowed = 1'b1;
					fr_cause = CAUSE_UNSPEC;
				end
				default: fr_cause = CAUSE_OTHER;
			endcase
		end
		q_push = cv_q && (port_q < 16'd10) && !q_full;
		// digits are produced lowest first, shifting in at the top, so the last
		// one lands in the top nibble
		q_data = '{ip: ip_q, digits: {rem, dig_q[19:4]}, ndig: nd_q + 3'd1,
			inbound: inb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			bcnt_q <= '0;
			cv_q <= 1'b0;
		end else begin
			if (wr_white)
				wcnt_q <= wcnt_q + 1'b1;
			if (wr_black)
				bcnt_q <= bcnt_q + 1'b1;
			if (in_valid && in_ready && cmd == CMD_CHECK && family == FAM_IPV4)
				cv_q <= 1'b1;
			else if (q_push)
				cv_q <= 1'b0;
		end
	end

	// one decimal digit per cycle
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			port_q <= peer_port;
			dig_q <= '0;
			nd_q <= '0;
			ip_q <= peer_ip;
			inb_q <= inbound;
		end else if (cv_q && port_q >= 16'd10) begin
			port_q <= quo;
			dig_q <= {rem, dig_q[19:4]};
			nd_q <= nd_q + 3'd1;
		end
	end
endmodule

@@ design/acl_queue.sv @@
// Small FIFO between front end and scan engine
module acl_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input acl_pkg::chk_t wdata,
	output logic full,
	input logic pop,
	output logic nempty,
	output acl_pkg::chk_t rdata
);
	import acl_pkg::*;

	localparam int AW = $clog2(QDEPTH);
	chk_t mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(QDEPTH);
	assign nempty = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk)
		if (push)
			mem_q[wp_q] <= wdata;
endmodule

@@ design/acl_scan.sv @@
// Back end: rule tables and one-rule-per-cycle scan of blacklist then whitelist
module acl_scan (
	input logic clk,
	input logic arst_n,
	input logic wr_white,
	input logic wr_black,
	input logic [acl_pkg::WIDX_W-1:0] wr_widx,
	input logic [acl_pkg::BIDX_W-1:0] wr_bidx,
	input acl_pkg::rule_t wr_rule,
	input logic [acl_pkg::WCNT_W-1:0] white_cnt,
	input logic [acl_pkg::BCNT_W-1:0] black_cnt,
	input logic q_nempty,
	input acl_pkg::chk_t q_data,
	output logic q_pop,
	output logic sc_valid,
	output logic sc_allowed,
	output logic [2:0] sc_cause,
	output logic [5:0] sc_hit,
	output logic busy
);
	import acl_pkg::*;

	rule_t wmem_q [WHITE_DEPTH];
	rule_t bmem_q [BLACK_DEPTH];
	rule_t rd_q;
	scan_st_t st_q, st_d;
	logic [WCNT_W-1:0] idx_q, idx_d;
	logic [WCNT_W-1:0] ridx_q;
	logic rv_q, rv_d, rwhite_q;
	chk_t cur_q;
	logic match;
	logic [WCNT_W-1:0] lim;

	always_ff @(posedge clk) begin
		if (wr_white)
			wmem_q[wr_widx] <= wr_rule;
		if (wr_black)
			bmem_q[wr_bidx] <= wr_rule;
		if (st_q == ST_BLACK)
			rd_q <= bmem_q[idx_q[BIDX_W-1:0]];
		else
			rd_q <= wmem_q[idx_q[WIDX_W-1:0]];
		if (q_pop)
			cur_q <= q_data;
	end

	always_comb begin
		match = ip_match(rd_q, cur_q.ip)
			&& glob_match(rd_q.chars, rd_q.len, cur_q.digits, cur_q.ndig)
			&& ((rd_q.dir == DIR_ANY) || (rd_q.dir == DIR_IN && cur_q.inbound)
				|| (rd_q.dir == DIR_OUT && !cur_q.inbound));
		lim = (st_q == ST_BLACK) ? WCNT_W'(black_cnt) : white_cnt;
	end

	always_comb begin
		st_d = st_q;
		idx_d = idx_q;
		rv_d = 1'b0;
		q_pop = 1'b0;
		sc_valid = 1'b0;
		sc_allowed = 1'b0;
		sc_cause = CAUSE_NOT_WHITE;
		sc_hit = '0;
		if (rv_q && match) begin
			sc_valid = 1'b1;
			sc_allowed = rwhite_q;
			sc_cause = rwhite_q ? CAUSE_WHITE_HIT : CAUSE_BLACK_HIT;
			sc_hit = 6'(ridx_q);
		end
		unique case (st_q)
			ST_IDLE: begin
				if (q_nempty) begin
					q_pop = 1'b1;
					st_d = ST_BLACK;
					idx_d = '0;
				end
			end
			ST_BLACK, ST_WHITE: begin
				if (rv_q && match) begin
					st_d = ST_IDLE;
				end else if (idx_q < lim) begin
					rv_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end else if (st_q == ST_BLACK) begin
					st_d = ST_WHITE;
					idx_d = '0;
					if (rv_q)
						st_d = ST_DONE;  // drain last black read before switching
				end else if (!rv_q) begin
					sc_valid = 1'b1;
					st_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				st_d = ST_WHITE;
				idx_d = '0;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign busy = st_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			rv_q <= 1'b0;
			rwhite_q <= 1'b0;
			ridx_q <= '0;
		end else begin
			st_q <= st_d;
			idx_q <= idx_d;
			rv_q <= rv_d;
			rwhite_q <= (st_q == ST_WHITE);
			ridx_q <= idx_q;
		end
	end
endmodule

@@ design/acl_checker.sv @@
// Port-level checker for the ACL classifier, bound to the top level
`include "assert_macros.svh"
module acl_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cmd,
	input logic done,
	input logic allowed,
	input logic [2:0] cause,
	input logic [5:0] hit_index
);
	import acl_pkg::*;

	logic is_hit;
	logic allow_cause;

	assign is_hit = cause == CAUSE_BLACK_HIT || cause == CAUSE_WHITE_HIT;
	assign allow_cause = cause == CAUSE_WHITE_HIT || cause == CAUSE_UNSPEC
		|| cause == CAUSE_ADDED;

	`ASSERT_IMPL(a_deny_hit, clk, arst_n, done && !is_hit, hit_index == 6'd0, "hit index without a hit")
	`ASSERT_IMPL(a_allow_cause, clk, arst_n, done && allowed, allow_cause, "allowed with a deny cause")
	`ASSERT_IMPL(a_deny_cause, clk, arst_n, done && !allowed, !allow_cause, "denied with an allow cause")
	`ASSERT_NEXT(a_add_done, clk, arst_n, start && !busy && cmd == CMD_ADD, done, "add not answered")
endmodule

bind connection_acl_classifier acl_checker u_acl_checker (
	.clk, .arst_n, .start, .busy, .cmd, .done, .allowed, .cause, .hit_index
);

@@ dv/testbench.sv @@
// Self-checking testbench for the connection ACL classifier
`timescale 1ns / 100ps

module testbench;
	import acl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_RANDOM = 1930;

	typedef struct {
		logic cmd;
		logic [1:0] list;
		logic [31:0] rip;
		logic [3:0] wild;
		logic [23:0] chars;
		logic [2:0] plen;
		logic [1:0] dir;
		logic [1:0] fam;
		logic [31:0] pip;
		logic [15:0] pport;
		logic inb;
	} acl_req_t;

	typedef struct {
		logic allowed;
		logic [2:0] cause;
		logic [5:0] hit;
	} verdict_t;

	typedef struct {
		acl_req_t req;
		bit typed;
		verdict_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic [1:0] rule_list = '0;
	logic [31:0] rule_ip = '0;
	logic [3:0] rule_octet_wild = '0;
	logic [23:0] rule_port_chars = '0;
	logic [2:0] rule_port_len = '0;
	logic [1:0] rule_dir = '0;
	logic [1:0] family = '0;
	logic [31:0] peer_ip = '0;
	logic [15:0] peer_port = '0;
	logic inbound = 1'b0;
	logic done;
	logic allowed;
	logic [2:0] cause;
	logic [5:0] hit_index;

	// mirror of the rule tables
	rule_t white_rules [WHITE_DEPTH];
	rule_t black_rules [BLACK_DEPTH];
	int white_used = 0;
	int black_used = 0;

	verdict_t pending_verdicts [$];
	int errors = 0;
	int cycles = 0;
	stim_row_t directed [$];

	connection_acl_classifier dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void add_row(stim_row_t r);
		directed.insert(directed.size(), r);
	endfunction

	// glob over the decimal text of the port
	function automatic bit port_glob(rule_t r, logic [15:0] port);
		int dg [5];
		int rev [5];
		int nd;
		int v;
		bit m [0:6][0:5];
		logic [3:0] c;
		nd = 0;
		v = int'(port);
		do begin
			rev[nd] = v % 10;
			v = v / 10;
			nd++;
		end while (v != 0);
		for (int k = 0; k < nd; k++)
			dg[k] = rev[nd - 1 - k];
		for (int i = 0; i <= 6; i++)
			for (int j = 0; j <= 5; j++)
				m[i][j] = 1'b0;
		m[0][0] = 1'b1;
		for (int i = 1; i <= r.len; i++) begin
			c = r.chars[23 - 4 * (i - 1) -: 4];
			for (int j = 0; j <= nd; j++) begin
				if (c == CH_STAR)
					m[i][j] = m[i-1][j] | ((j > 0) ? m[i][j-1] : 1'b0);
				else if (j > 0)
					m[i][j] = m[i-1][j-1] & ((c == CH_ANY1) || (c < 10 && c == dg[j-1]));
			end
		end
		return (r.len != 0) && m[r.len][nd];
	endfunction

	function automatic bit rule_hits(rule_t r, acl_req_t q);
		for (int o = 0; o < 4; o++)
			if (!r.wild[3-o] && r.ip[31-8*o -: 8] != q.pip[31-8*o -: 8])
				return 1'b0;
		if (!port_glob(r, q.pport))
			return 1'b0;
		case (r.dir)
			DIR_ANY: return 1'b1;
			DIR_IN: return q.inb;
			DIR_OUT: return !q.inb;
			default: return 1'b0;
		endcase
	endfunction

	function automatic verdict_t classify(acl_req_t q);
		verdict_t v;
		rule_t r;
		v = '{1'b0, CAUSE_IGNORED, 6'd0};
		if (q.cmd == CMD_ADD) begin
			r.ip = q.rip;
			r.wild = q.wild;
			r.chars = q.chars;
			r.len = (q.plen > PORT_PAT_LEN) ? 3'(PORT_PAT_LEN) : q.plen;
			r.dir = q.dir;
			if (q.list == LIST_WHITE && white_used < WHITE_DEPTH) begin
				white_rules[white_used++] = r;
				v = '{1'b1, CAUSE_ADDED, 6'd0};
			end else if (q.list == LIST_BLACK && black_used < BLACK_DEPTH) begin
				black_rules[black_used++] = r;
				v = '{1'b1, CAUSE_ADDED, 6'd0};
			end
			return v;
		end
		case (q.fam)
			FAM_IPV6: return '{1'b0, CAUSE_IPV6, 6'd0};
			FAM_UNSPEC: return '{1'b1, CAUSE_UNSPEC, 6'd0};
			FAM_OTHER: return '{1'b0, CAUSE_OTHER, 6'd0};
			default: ;
		endcase
		for (int i = 0; i < black_used; i++)
			if (rule_hits(black_rules[i], q))
				return '{1'b0, CAUSE_BLACK_HIT, 6'(i)};
		for (int i = 0; i < white_used; i++)
			if (rule_hits(white_rules[i], q))
				return '{1'b1, CAUSE_WHITE_HIT, 6'(i)};
		return '{1'b0, CAUSE_NOT_WHITE, 6'd0};
	endfunction

	function automatic acl_req_t noise_req();
		acl_req_t q;
		q.cmd = 1'($urandom);
		q.list = 2'($urandom);
		q.rip = $urandom;
		q.wild = 4'($urandom);
		q.chars = 24'($urandom);
		q.plen = 3'($urandom);
		q.dir = 2'($urandom);
		q.fam = 2'($urandom);
		q.pip = $urandom;
		q.pport = 16'($urandom);
		q.inb = 1'($urandom);
		return q;
	endfunction

	function automatic acl_req_t add_req(logic [1:0] lst, logic [31:0] ip, logic [3:0] wl,
			logic [23:0] ch, logic [2:0] ln, logic [1:0] dr);
		acl_req_t q;
		q = noise_req();
		q.cmd = CMD_ADD;
		q.list = lst;
		q.rip = ip;
		q.wild = wl;
		q.chars = ch;
		q.plen = ln;
		q.dir = dr;
		return q;
	endfunction

	function automatic acl_req_t chk_req(logic [1:0] fm, logic [31:0] ip, logic [15:0] pt,
			logic ib);
		acl_req_t q;
		q = noise_req();
		q.cmd = CMD_CHECK;
		q.fam = fm;
		q.pip = ip;
		q.pport = pt;
		q.inb = ib;
		return q;
	endfunction

	function automatic acl_req_t rand_add();
		logic [23:0] ch;
		int p;
		for (int k = 0; k < 6; k++) begin
			p = $urandom_range(99);
			if (p < 70) ch[23-4*k -: 4] = 4'($urandom_range(9));
			else if (p < 82) ch[23-4*k -: 4] = CH_ANY1;
			else if (p < 94) ch[23-4*k -: 4] = CH_STAR;
			else ch[23-4*k -: 4] = 4'($urandom_range(15, 12));
		end
		return add_req(($urandom_range(19) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom),
			($urandom_range(3) == 0) ? $urandom : {8'd10, 8'd0, 8'($urandom_range(3)),
			8'($urandom_range(7))}, ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom), ch,
			3'($urandom_range(7)), ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)));
	endfunction

	// builds a connection aimed at a stored rule so that scans get real hits
	function automatic acl_req_t aimed_check();
		rule_t r;
		acl_req_t q;
		logic [3:0] c;
		int val;
		int n;
		int d;
		int first;
		bit ok;
		if (white_used + black_used == 0 || $urandom_range(4) == 0)
			return chk_req(FAM_IPV4, ($urandom_range(1) == 0) ? $urandom :
				{8'd10, 8'd0, 8'($urandom_range(3)), 8'($urandom_range(7))},
				($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(999)),
				1'($urandom));
		if (black_used > 0 && $urandom_range(2) == 0)
			r = black_rules[$urandom_range(black_used - 1)];
		else if (white_used > 0)
			r = white_rules[$urandom_range(white_used - 1)];
		else
			r = black_rules[$urandom_range(black_used - 1)];
		q = chk_req(FAM_IPV4, r.ip, 16'($urandom_range(999)), 1'($urandom));
		for (int o = 0; o < 4; o++)
			if (r.wild[3-o])
				q.pip[31-8*o -: 8] = 8'($urandom);
		val = 0;
		n = 0;
		first = 0;
		ok = 1'b1;
		for (int k = 0; k < r.len; k++) begin
			c = r.chars[23-4*k -: 4];
			if (c < 10) d = int'(c);
			else if (c == CH_ANY1 || (c == CH_STAR && $urandom_range(1) == 0))
				d = int'($urandom_range(9));
			else if (c == CH_STAR) continue;
			else begin
				ok = 1'b0;
				d = 0;
			end
			if (n == 0) first = d;
			val = val * 10 + d;
			n++;
		end
		if (ok && n > 0 && n <= 5 && val <= 65535 && !(n > 1 && first == 0))
			q.pport = 16'(val);
		return q;
	endfunction

	task automatic send(acl_req_t q, int gap_pct, bit typed, verdict_t want);
		verdict_t v;
		@(negedge clk);
		start <= 1'b1;
		cmd <= q.cmd;
		rule_list <= q.list;
		rule_ip <= q.rip;
		rule_octet_wild <= q.wild;
		rule_port_chars <= q.chars;
		rule_port_len <= q.plen;
		rule_dir <= q.dir;
		family <= q.fam;
		peer_ip <= q.pip;
		peer_port <= q.pport;
		inbound <= q.inb;
		do @(posedge clk); while (busy);
		v = classify(q);
		pending_verdicts.insert(pending_verdicts.size(), typed ? want : v);
		if ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected transaction: allowed %0b cause %0d hit %0d",
					$time, allowed, cause, hit_index);
				errors++;
			end else begin
				w = pending_verdicts.pop_front();
				if (allowed !== w.allowed) begin
					$display("%0t: allowed expected %0b actual %0b", $time, w.allowed, allowed);
					errors++;
				end
				if (cause !== w.cause) begin
					$display("%0t: cause expected %0d actual %0d", $time, w.cause, cause);
					errors++;
				end
				if (hit_index !== w.hit) begin
					$display("%0t: hit_index expected %0d actual %0d", $time, w.hit, hit_index);
					errors++;
				end
			end
		end
	end

	initial begin
		int gap_pct;
		verdict_t none;
		none = '{1'b0, 3'd0, 6'd0};
		add_row('{chk_req(FAM_IPV4, 32'hC0A8010A, 16'd80, 1'b1), 1'b1,
			'{1'b0, CAUSE_NOT_WHITE, 6'd0}});
		add_row('{chk_req(FAM_IPV6, 32'h0, 16'd0, 1'b0), 1'b1,
			'{1'b0, CAUSE_IPV6, 6'd0}});
		add_row('{chk_req(FAM_UNSPEC, 32'hFFFFFFFF, 16'hFFFF, 1'b1), 1'b1,
			'{1'b1, CAUSE_UNSPEC, 6'd0}});
		add_row('{chk_req(FAM_OTHER, 32'h01020304, 16'd443, 1'b0), 1'b1,
			'{1'b0, CAUSE_OTHER, 6'd0}});
		add_row('{add_req(2'd2, 32'h0A000001, 4'h0, 24'h800000, 3'd2, DIR_ANY),
			1'b1, '{1'b0, CAUSE_IGNORED, 6'd0}});
		add_row('{add_req(2'd3, 32'h0A000001, 4'h0, 24'h800000, 3'd2, DIR_ANY),
			1'b1, '{1'b0, CAUSE_IGNORED, 6'd0}});
		add_row('{add_req(LIST_WHITE, 32'hC0A8010A, 4'h0, 24'h800000, 3'd2,
			DIR_ANY), 1'b1, '{1'b1, CAUSE_ADDED, 6'd0}});
		add_row('{add_req(LIST_WHITE, 32'h0A000000, 4'h3, 24'hB00000, 3'd1, DIR_IN),
			1'b0, none});
		add_row('{add_req(LIST_BLACK, 32'h0A000042, 4'h0, 24'hAA0000, 3'd2,
			DIR_OUT), 1'b0, none});
		// empty pattern never matches
		add_row('{add_req(LIST_WHITE, 32'h0, 4'hF, 24'h000000, 3'd0, DIR_ANY),
			1'b0, none});
		// length above six saturates; direction 3 matches nothing
		add_row('{add_req(LIST_WHITE, 32'hFFFFFFFF, 4'h0, 24'hBBBBBB, 3'd7, 2'd3),
			1'b0, none});
		add_row('{add_req(LIST_BLACK, 32'h0, 4'hF, 24'hCDEFCD, 3'd6, DIR_ANY),
			1'b0, none});
		// trailing chars past the length are ignored
		add_row('{add_req(LIST_WHITE, 32'h0, 4'hF, 24'h1AB537, 3'd4, DIR_OUT),
			1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'hC0A8010A, 16'd80, 1'b1), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'hC0A8010A, 16'd8080, 1'b1), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'h0A000506, 16'd0, 1'b1), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'h0A000042, 16'd12, 1'b0), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'h0A000042, 16'd12, 1'b1), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'hFFFFFFFF, 16'hFFFF, 1'b1), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'h01020304, 16'd125, 1'b0), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'h01020304, 16'd15, 1'b0), 1'b0, none});
		add_row('{chk_req(FAM_IPV4, 32'h09090909, 16'd65535, 1'b0), 1'b0, none});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send(directed[i].req, 0, directed[i].typed, directed[i].want);
		drain();
		// hold off until the block is empty
		repeat (20) @(negedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			case (i * 4 / N_RANDOM)
				0: gap_pct = 0;
				1: gap_pct = 69;
				2: gap_pct = 17;
				default: gap_pct = (i % 200 < 100) ? 0 : 69;
			endcase
			if (i % (N_RANDOM / 4) == 0 && i != 0)
				drain();
			case ($urandom_range(99)) inside
				[0:14]: send(rand_add(), gap_pct, 1'b0, none);
				[15:19]: send(noise_req(), gap_pct, 1'b0, none);
				[20:27]: send(chk_req(2'($urandom_range(3, 1)), $urandom, 16'($urandom),
					1'($urandom)), gap_pct, 1'b0, none);
				default: send(aimed_check(), gap_pct, 1'b0, none);
			endcase
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
